// File: sv/clcd_pkg.sv
package clcd_pkg;

  localparam int STEP_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [2:0] OP_DATA = 3'd0;
  localparam logic [2:0] OP_COMMAND = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_HOME = 3'd3;
  localparam logic [2:0] OP_CURSOR = 3'd4;
  localparam logic [2:0] OP_INIT = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_FUNCTION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3 = 3'd5;

  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_HOME = 8'h02;
  localparam logic [7:0] CMD_ENTRY = 8'h06;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
  localparam logic [7:0] CMD_FUNC = 8'h20;
  localparam logic [7:0] CMD_DDRAM = 8'h80;
  localparam logic [7:0] NIB_WAKE = 8'h03;
  localparam logic [7:0] NIB_4BIT = 8'h02;
  localparam logic [5:0] POWERUP_MS = 6'd60;

  typedef struct packed {
    logic [4:0]      function_bits;
    logic [2:0]      line_count;
    logic [3:0][6:0] row_offset;
  } cfg_t;

  // Transfer shape of one microstep
  typedef enum logic [1:0] {
    MODE_BYTE,
    MODE_NIBBLE,
    MODE_POWER
  } mode_t;

  // Byte that one microstep sends
  typedef enum logic [3:0] {
    SRC_VALUE,
    SRC_CLEAR,
    SRC_HOME,
    SRC_CURSOR,
    SRC_FUNC,
    SRC_DISPLAY,
    SRC_ENTRY,
    SRC_WAKE,
    SRC_4BIT,
    SRC_ZERO
  } src_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_BUS8
  } jmp_t;

  typedef struct packed {
    mode_t             mode;
    src_t              src;
    logic [2:0]        extra;
    logic              rs;
    logic              fin;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } ucode_t;

  localparam logic [STEP_W-1:0] STEP_DATA = 5'd0;
  localparam logic [STEP_W-1:0] STEP_COMMAND = 5'd1;
  localparam logic [STEP_W-1:0] STEP_CLEAR = 5'd2;
  localparam logic [STEP_W-1:0] STEP_HOME = 5'd3;
  localparam logic [STEP_W-1:0] STEP_CURSOR = 5'd4;
  localparam logic [STEP_W-1:0] STEP_INIT = 5'd5;
  localparam logic [STEP_W-1:0] STEP_INIT8 = 5'd10;
  localparam logic [STEP_W-1:0] STEP_TAIL = 5'd13;

  function automatic ucode_t uword(input mode_t mode, input src_t src,
                                   input logic [2:0] extra, input logic rs,
                                   input logic fin, input jmp_t jmp,
                                   input logic [STEP_W-1:0] target);
    ucode_t w;
    w.mode = mode;
    w.src = src;
    w.extra = extra;
    w.rs = rs;
    w.fin = fin;
    w.jmp = jmp;
    w.target = target;
    return w;
  endfunction

  // Control store: single-step programs for the simple operations, then the
  // power-up program with its four-bit and eight-bit branches.
  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      5'd0:  w = uword(MODE_BYTE, SRC_VALUE, 3'd0, 1'b1, 1'b1, JMP_NONE, '0);
      5'd1:  w = uword(MODE_BYTE, SRC_VALUE, 3'd0, 1'b0, 1'b1, JMP_NONE, '0);
      5'd2:  w = uword(MODE_BYTE, SRC_CLEAR, 3'd2, 1'b0, 1'b1, JMP_NONE, '0);
      5'd3:  w = uword(MODE_BYTE, SRC_HOME, 3'd2, 1'b0, 1'b1, JMP_NONE, '0);
      5'd4:  w = uword(MODE_BYTE, SRC_CURSOR, 3'd0, 1'b0, 1'b1, JMP_NONE, '0);
      5'd5:  w = uword(MODE_POWER, SRC_ZERO, 3'd0, 1'b0, 1'b0, JMP_BUS8, STEP_INIT8);
      5'd6:  w = uword(MODE_NIBBLE, SRC_WAKE, 3'd5, 1'b0, 1'b0, JMP_NONE, '0);
      5'd7:  w = uword(MODE_NIBBLE, SRC_WAKE, 3'd1, 1'b0, 1'b0, JMP_NONE, '0);
      5'd8:  w = uword(MODE_NIBBLE, SRC_WAKE, 3'd1, 1'b0, 1'b0, JMP_NONE, '0);
      5'd9:  w = uword(MODE_NIBBLE, SRC_4BIT, 3'd0, 1'b0, 1'b0, JMP_ALWAYS, STEP_TAIL);
      5'd10: w = uword(MODE_BYTE, SRC_FUNC, 3'd6, 1'b0, 1'b0, JMP_NONE, '0);
      5'd11: w = uword(MODE_BYTE, SRC_FUNC, 3'd1, 1'b0, 1'b0, JMP_NONE, '0);
      5'd12: w = uword(MODE_BYTE, SRC_FUNC, 3'd0, 1'b0, 1'b0, JMP_NONE, '0);
      5'd13: w = uword(MODE_BYTE, SRC_FUNC, 3'd0, 1'b0, 1'b0, JMP_NONE, '0);
      5'd14: w = uword(MODE_BYTE, SRC_DISPLAY, 3'd0, 1'b0, 1'b0, JMP_NONE, '0);
      5'd15: w = uword(MODE_BYTE, SRC_CLEAR, 3'd2, 1'b0, 1'b0, JMP_NONE, '0);
      5'd16: w = uword(MODE_BYTE, SRC_ENTRY, 3'd0, 1'b0, 1'b1, JMP_NONE, '0);
      default: w = uword(MODE_POWER, SRC_ZERO, 3'd0, 1'b0, 1'b1, JMP_NONE, '0);
    endcase
    return w;
  endfunction

endpackage

// File: sv/clcd_cfg_regs.sv
module clcd_cfg_regs
  import clcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.function_bits <= 5'd8;
      cfg.line_count <= 3'd2;
      cfg.row_offset[0] <= 7'd0;
      cfg.row_offset[1] <= 7'd64;
      cfg.row_offset[2] <= 7'd16;
      cfg.row_offset[3] <= 7'd80;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FUNCTION: cfg.function_bits <= wr_data[4:0];
        REG_LINES:    cfg.line_count <= wr_data[2:0];
        REG_ROW0:     cfg.row_offset[0] <= wr_data;
        REG_ROW1:     cfg.row_offset[1] <= wr_data;
        REG_ROW2:     cfg.row_offset[2] <= wr_data;
        REG_ROW3:     cfg.row_offset[3] <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/clcd_operand.sv
module clcd_operand
  import clcd_pkg::*;
#(
  parameter int MAX_ROWS = 4
) (
  input  logic       clk,
  input  logic       load,
  input  logic [7:0] value,
  input  logic [7:0] column,
  input  logic [7:0] row,
  input  cfg_t       cfg,
  input  src_t       src,
  output logic [7:0] byte_out
);

  logic [7:0] value_q;
  logic [7:0] column_q;
  logic [7:0] row_q;
  logic [7:0] row_max;
  logic [7:0] row_lines;
  logic [7:0] row_sat;
  logic [7:0] lines;
  logic [7:0] cursor;

  always_ff @(posedge clk) begin
    if (load) begin
      value_q <= value;
      column_q <= column;
      row_q <= row;
    end
  end

  // Saturate the row at the table size, then the line count, then the four offsets
  always_comb begin
    lines = (cfg.line_count == 3'd0) ? 8'd1 : {5'd0, cfg.line_count};
    row_max = (row_q >= 8'(MAX_ROWS)) ? 8'(MAX_ROWS - 1) : row_q;
    row_lines = (row_max >= lines) ? lines - 8'd1 : row_max;
    row_sat = (row_lines > 8'd3) ? 8'd3 : row_lines;
    cursor = CMD_DDRAM | (column_q + {1'b0, cfg.row_offset[row_sat[1:0]]});
  end

  always_comb begin
    unique case (src)
      SRC_VALUE:   byte_out = value_q;
      SRC_CLEAR:   byte_out = CMD_CLEAR;
      SRC_HOME:    byte_out = CMD_HOME;
      SRC_CURSOR:  byte_out = cursor;
      SRC_FUNC:    byte_out = CMD_FUNC | {3'd0, cfg.function_bits};
      SRC_DISPLAY: byte_out = CMD_DISPLAY_ON;
      SRC_ENTRY:   byte_out = CMD_ENTRY;
      SRC_WAKE:    byte_out = NIB_WAKE;
      SRC_4BIT:    byte_out = NIB_4BIT;
      default:     byte_out = 8'd0;
    endcase
  end

endmodule

// File: sv/clcd_sequencer.sv
module clcd_sequencer
  import clcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  op,
  input  logic        bus8,
  input  logic [7:0]  byte_in,
  output src_t        src,
  output logic        ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_rs,
  output logic        out_en,
  output logic [7:0]  out_bus,
  output logic [5:0]  out_hold,
  output logic        out_last
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic              nib;
  logic [1:0]        phase;
  ucode_t            cw;
  logic              fire;
  logic              final_xfer;
  logic              step_done;
  logic              snap_en;
  logic [7:0]        snap_bus;
  logic [5:0]        snap_hold;
  logic              snap_last;
  logic [STEP_W-1:0] step_next;

  assign cw = ucode(step);
  assign src = cw.src;
  assign fire = busy && (!out_valid || out_ready);
  assign ready = !busy || (fire && snap_last);

  always_comb begin
    final_xfer = (cw.mode != MODE_BYTE) || bus8 || nib;
    step_done = (cw.mode == MODE_POWER) || (phase == 2'd2 && final_xfer);
    snap_last = step_done && cw.fin;
    if (cw.mode == MODE_POWER) begin
      snap_en = 1'b0;
      snap_bus = 8'd0;
      snap_hold = POWERUP_MS;
    end else begin
      snap_en = (phase == 2'd1);
      if (cw.mode == MODE_BYTE && bus8) begin
        snap_bus = byte_in;
      end else if (cw.mode == MODE_BYTE && !nib) begin
        snap_bus = {4'd0, byte_in[7:4]};
      end else begin
        snap_bus = {4'd0, byte_in[3:0]};
      end
      snap_hold = step_done ? 6'd1 + {3'd0, cw.extra} : 6'd1;
    end
    priority case (cw.jmp)
      JMP_ALWAYS: step_next = cw.target;
      JMP_BUS8:   step_next = bus8 ? cw.target : step + STEP_W'(1);
      default:    step_next = step + STEP_W'(1);
    endcase
  end

  // A new item only arrives as the last snapshot of the previous one is loaded,
  // so the start branch takes over everything that snapshot would have set
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      nib <= 1'b0;
      phase <= 2'd0;
    end else if (start) begin
      phase <= 2'd0;
      nib <= 1'b0;
      priority case (op)
        OP_DATA:    begin busy <= 1'b1; step <= STEP_DATA; end
        OP_COMMAND: begin busy <= 1'b1; step <= STEP_COMMAND; end
        OP_CLEAR:   begin busy <= 1'b1; step <= STEP_CLEAR; end
        OP_HOME:    begin busy <= 1'b1; step <= STEP_HOME; end
        OP_CURSOR:  begin busy <= 1'b1; step <= STEP_CURSOR; end
        OP_INIT:    begin busy <= 1'b1; step <= STEP_INIT; end
        default:    busy <= 1'b0;
      endcase
    end else if (fire) begin
      if (step_done) begin
        phase <= 2'd0;
        nib <= 1'b0;
        if (cw.fin) begin
          busy <= 1'b0;
        end else begin
          step <= step_next;
        end
      end else if (phase == 2'd2) begin
        phase <= 2'd0;
        nib <= 1'b1;
      end else begin
        phase <= phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_rs <= cw.rs;
      out_en <= snap_en;
      out_bus <= snap_bus;
      out_hold <= snap_hold;
      out_last <= snap_last;
    end
  end

endmodule

// File: sv/char_lcd_bus_sequencer.sv
// Channel   Direction  Handshake                 Payload
// s_*       in         s_tvalid / s_tready       tuser operation, tdata value/column/row
// m_*       out        m_tvalid / m_tready       tuser register_select, tdata snapshot, tlast
// cfg_*     in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One pin snapshot leaves per cycle while the sink is ready; an operation has
// 3 or 6 snapshots per byte (37 for a 4-bit initialise), and the next item is
// taken in the cycle its last snapshot is loaded. The microcode step counter
// walks one phase a cycle while the sink is ready.
// A stalled sink holds the output register and freezes the step counter.
// Reset (synchronous) restores the register defaults and empties the output.
module char_lcd_bus_sequencer
  import clcd_pkg::*;
#(
  parameter int MAX_ROWS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,   // value[7:0], column[15:8], row[23:16]
  input  logic [2:0]            s_tuser,   // operation[2:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // read_write[0], enable_level[1],
                                           // bus_value[9:2], hold_ms[15:10]
  output logic                  m_tuser,   // register_select[0]
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  src_t       src;
  logic       s_accept;
  logic [7:0] byte_sel;
  logic       out_en;
  logic [7:0] out_bus;
  logic [5:0] out_hold;

  // Register writes land at once; the host must write only while the block is idle (not enforced here)
  assign cfg_ready = 1'b1;
  assign s_accept = s_tvalid && s_tready;

  clcd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Hold the item fields and form the byte each microstep asks for
  clcd_operand #(
    .MAX_ROWS (MAX_ROWS)
  ) u_operand (
    .clk      (clk),
    .load     (s_accept),
    .value    (s_tdata[7:0]),
    .column   (s_tdata[15:8]),
    .row      (s_tdata[23:16]),
    .cfg      (cfg),
    .src      (src),
    .byte_out (byte_sel)
  );

  // Walk the control store, splitting bytes into nibbles and enable phases
  clcd_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (s_accept),
    .op        (s_tuser),
    .bus8      (cfg.function_bits[4]),
    .byte_in   (byte_sel),
    .src       (src),
    .ready     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rs    (m_tuser),
    .out_en    (out_en),
    .out_bus   (out_bus),
    .out_hold  (out_hold),
    .out_last  (m_tlast)
  );

  // Read/write pin always drives write
  assign m_tdata = {out_hold, out_bus, out_en, 1'b0};

endmodule

// File: sv/clcd_checker.sv
module clcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // Stalled beat holds its payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled output beat changed");

  // Strobe-high phase is always 1 ms and never ends an operation
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[15:10] == 6'd1 && !m_tlast)
    else $error("enable-high beat malformed");

  // Enable high must follow a low phase with the same bus value
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tdata[1] && m_tdata[15:10] == 6'd1 && !m_tlast
      ##1 m_tvalid && m_tdata[1] |-> $stable(m_tdata[9:2]))
    else $error("bus changed across enable rise");

  // Final beat leaves enable low with read/write low
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tdata[1] && !m_tdata[0])
    else $error("final beat with enable or read high");

endmodule

bind char_lcd_bus_sequencer clcd_checker u_clcd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// File: test/tb_top.sv
module tb_top;
  import clcd_pkg::*;

  localparam int MAX_ROWS = 4;

  // Opcodes the block has no program for; they must produce no snapshots
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam int IDLE_PCT          = 28;    // chance in a hundred that a side idles
  localparam int SINK_HOLD_CYCLES  = 200;   // one long sink stall to back up the block
  localparam int CFG_SETTLE_CYCLES = 40;    // covers a spare opcode still in the block
  localparam int DRAIN_CYCLES      = 60;
  localparam int STALL_LIMIT       = 4000;  // cycles without any beat before giving up
  localparam int MAX_REPORTS       = 100;
  localparam int RANDOM_PHASES     = 8;
  localparam int PHASE_REQUESTS    = 48;

  // One request as it travels on the slave side
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] value;
    logic [7:0] column;
    logic [7:0] row;
  } lcd_req_t;

  // One pin snapshot as it leaves on the master side
  typedef struct packed {
    logic       rs;
    logic       rw;
    logic       en;
    logic [7:0] bus;
    logic [5:0] hold;
    logic       last;
  } pin_snap_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [23:0]           s_tdata = '0;   // value[7:0], column[15:8], row[23:16]
  logic [2:0]            s_tuser = '0;   // operation[2:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;        // read_write[0], enable_level[1],
                                         // bus_value[9:2], hold_ms[15:10]
  logic                  m_tuser;        // register_select[0]
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Mirror of the configuration registers, updated on each accepted write
  logic [4:0] lcd_func_bits;
  logic [2:0] lcd_lines;
  logic [6:0] lcd_row_base [4];

  lcd_req_t  req_pending [$];   // requests not yet put on the bus
  pin_snap_t snaps_due [$];     // predicted snapshots, oldest first
  lcd_req_t  req_on_bus;

  int  errors = 0;
  int  req_beats = 0;
  int  snap_beats = 0;
  int  init_count = 0;
  int  spare_count = 0;
  int  reg_writes = 0;
  int  quiet_cycles = 0;
  int  sink_hold_left = 0;
  bit  steady = 1'b0;       // both sides ready every cycle
  bit  hold_armed = 1'b0;
  bit  hold_done = 1'b0;

  char_lcd_bus_sequencer #(
    .MAX_ROWS(MAX_ROWS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Snapshot predictor
  // ---------------------------------------------------------------------------

  function automatic void push_snap(logic rs, logic en, logic [7:0] bus, logic [5:0] hold);
    pin_snap_t s;
    s.rs   = rs;
    s.rw   = 1'b0;
    s.en   = en;
    s.bus  = bus;
    s.hold = hold;
    s.last = 1'b0;
    snaps_due.push_back(s);
  endfunction

  // One transfer: enable low, high, low; any extra wait lands on the final phase
  function automatic void push_strobe(logic rs, logic [7:0] bus, logic [5:0] extra);
    push_snap(rs, 1'b0, bus, 6'd1);
    push_snap(rs, 1'b1, bus, 6'd1);
    push_snap(rs, 1'b0, bus, 6'd1 + extra);
  endfunction

  // Whole byte on an 8-bit bus, otherwise high nibble then low nibble
  function automatic void push_byte(logic rs, logic [7:0] b, logic [5:0] extra);
    if (lcd_func_bits[4]) begin
      push_strobe(rs, b, extra);
    end else begin
      push_strobe(rs, {4'h0, b[7:4]}, 6'd0);
      push_strobe(rs, {4'h0, b[3:0]}, extra);
    end
  endfunction

  function automatic void predict_request(lcd_req_t r);
    int unsigned start;
    int unsigned lines;
    int unsigned row;
    logic [7:0]  func_cmd;
    logic [7:0]  addr;
    pin_snap_t   tail;
    start    = snaps_due.size();
    func_cmd = CMD_FUNC | {3'b000, lcd_func_bits};
    case (r.op)
      OP_DATA:    push_byte(1'b1, r.value, 6'd0);
      OP_COMMAND: push_byte(1'b0, r.value, 6'd0);
      OP_CLEAR:   push_byte(1'b0, CMD_CLEAR, 6'd2);
      OP_HOME:    push_byte(1'b0, CMD_HOME, 6'd2);
      OP_CURSOR: begin
        // Saturate the row at the row limit, then at the line count
        // (zero counts as one line), then at the last offset register
        row = r.row;
        if (row >= MAX_ROWS) row = MAX_ROWS - 1;
        lines = lcd_lines;
        if (lines == 0) lines = 1;
        if (row >= lines) row = lines - 1;
        if (row > 3) row = 3;
        addr = r.column + {1'b0, lcd_row_base[row]};
        push_byte(1'b0, CMD_DDRAM | addr, 6'd0);
      end
      OP_INIT: begin
        init_count++;
        push_snap(1'b0, 1'b0, 8'h00, POWERUP_MS);
        if (lcd_func_bits[4]) begin
          push_byte(1'b0, func_cmd, 6'd6);
          push_byte(1'b0, func_cmd, 6'd1);
          push_byte(1'b0, func_cmd, 6'd0);
        end else begin
          push_strobe(1'b0, NIB_WAKE, 6'd5);
          push_strobe(1'b0, NIB_WAKE, 6'd1);
          push_strobe(1'b0, NIB_WAKE, 6'd1);
          push_strobe(1'b0, NIB_4BIT, 6'd0);
        end
        push_byte(1'b0, func_cmd, 6'd0);
        push_byte(1'b0, CMD_DISPLAY_ON, 6'd0);
        push_byte(1'b0, CMD_CLEAR, 6'd2);
        push_byte(1'b0, CMD_ENTRY, 6'd0);
      end
      default: spare_count++;   // spare opcodes send nothing
    endcase
    // Flag the final snapshot of this request
    if (snaps_due.size() > start) begin
      tail = snaps_due.pop_back();
      tail.last = 1'b1;
      snaps_due.push_back(tail);
    end
  endfunction

  function automatic void note_reg_write(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_FUNCTION: lcd_func_bits   = data[4:0];
      REG_LINES:    lcd_lines       = data[2:0];
      REG_ROW0:     lcd_row_base[0] = data;
      REG_ROW1:     lcd_row_base[1] = data;
      REG_ROW2:     lcd_row_base[2] = data;
      REG_ROW3:     lcd_row_base[3] = data;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Snapshot checker
  // ---------------------------------------------------------------------------

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic void check_beat();
    pin_snap_t want;
    pin_snap_t got;
    got = {m_tuser, m_tdata[0], m_tdata[1], m_tdata[9:2], m_tdata[15:10], m_tlast};
    snap_beats++;
    if (snaps_due.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: unexpected snapshot, expected none, actual %h", $time, got);
      return;
    end
    want = snaps_due.pop_front();
    compare_field("register_select", want.rs, got.rs);
    compare_field("read_write", want.rw, got.rw);
    compare_field("enable_level", want.en, got.en);
    compare_field("bus_value", want.bus, got.bus);
    compare_field("hold_ms", want.hold, got.hold);
    compare_field("last", want.last, got.last);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: predict on each accepted beat, then offer the next request
  // or idle. Valid only drops when the beat went through or nothing was up.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_request(req_on_bus);
        req_beats++;
      end
      if (!s_tvalid || s_tready) begin
        if (req_pending.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          req_on_bus = req_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= req_on_bus.op;
          s_tdata  <= {req_on_bus.row, req_on_bus.column, req_on_bus.value};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Snapshot monitor: check each accepted beat, then pick the next ready level.
  // Once armed, hold ready low for a long stretch so the block backs up.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_beat();
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        m_tready <= 1'b0;
      end else if (hold_armed && !hold_done) begin
        sink_hold_left = SINK_HOLD_CYCLES;
        hold_done = 1'b1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: drop the run if no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d snapshots still due",
               $time, quiet_cycles, snaps_due.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    note_reg_write(idx, data);
    reg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_req(logic [2:0] op, logic [7:0] value, logic [7:0] column,
                           logic [7:0] row);
    lcd_req_t r;
    r.op     = op;
    r.value  = value;
    r.column = column;
    r.row    = row;
    req_pending.push_back(r);
  endtask

  // Wait until every request is in and every snapshot is out, then give a
  // trailing spare opcode time to leave the block before touching registers
  task automatic settle();
    while (req_pending.size() != 0 || s_tvalid || snaps_due.size() != 0)
      @(posedge clk);
    repeat (CFG_SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random_req();
    int unsigned pick;
    logic [2:0]  op;
    logic [7:0]  row;
    pick = $urandom_range(99);
    if (pick < 24)      op = OP_DATA;
    else if (pick < 44) op = OP_COMMAND;
    else if (pick < 52) op = OP_CLEAR;
    else if (pick < 60) op = OP_HOME;
    else if (pick < 88) op = OP_CURSOR;
    else if (pick < 94) op = OP_INIT;
    else                op = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
    // Keep half the rows near the clamp points, the rest anywhere
    row = $urandom_range(1) ? 8'($urandom_range(5)) : 8'($urandom_range(255));
    queue_req(op, 8'($urandom_range(255)), 8'($urandom_range(255)), row);
  endtask

  // Write every register; wide data exercises masking, line count leans legal
  task automatic random_config();
    write_reg(REG_FUNCTION, 7'($urandom_range(127)));
    write_reg(REG_LINES, ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                                  : 7'($urandom_range(4, 1)));
    write_reg(REG_ROW0, 7'($urandom_range(127)));
    write_reg(REG_ROW1, 7'($urandom_range(127)));
    write_reg(REG_ROW2, 7'($urandom_range(127)));
    write_reg(REG_ROW3, 7'($urandom_range(127)));
  endtask

  initial begin
    // Reset values of the registers
    lcd_func_bits   = 5'd8;
    lcd_lines       = 3'd2;
    lcd_row_base[0] = 7'd0;
    lcd_row_base[1] = 7'd64;
    lcd_row_base[2] = 7'd16;
    lcd_row_base[3] = 7'd80;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: 4-bit bus, two lines
    queue_req(OP_DATA, 8'h00, 8'h00, 8'h00);
    queue_req(OP_DATA, 8'hFF, 8'hFF, 8'hFF);
    queue_req(OP_DATA, 8'hA5, 8'h5A, 8'h33);
    queue_req(OP_COMMAND, 8'h00, 8'hFF, 8'h00);
    queue_req(OP_COMMAND, 8'hFF, 8'h00, 8'hFF);
    queue_req(OP_CLEAR, 8'h5A, 8'h00, 8'h00);
    queue_req(OP_HOME, 8'hA5, 8'h00, 8'h00);
    queue_req(OP_CURSOR, 8'h00, 8'h00, 8'h00);
    queue_req(OP_CURSOR, 8'h00, 8'hFF, 8'hFF);   // row far past the offsets, column wraps
    queue_req(OP_CURSOR, 8'h00, 8'd10, 8'd1);
    queue_req(OP_CURSOR, 8'h00, 8'd200, 8'd2);   // row beyond the line count
    queue_req(OP_INIT, 8'h00, 8'h00, 8'h00);
    queue_req(OP_SPARE_6, 8'hFF, 8'hFF, 8'hFF);
    queue_req(OP_SPARE_7, 8'h00, 8'h00, 8'h00);
    settle();

    // Top extremes: 8-bit bus with every flag, four lines, highest offsets
    write_reg(REG_FUNCTION, 7'h7F);
    write_reg(REG_LINES, 7'd4);
    write_reg(REG_ROW0, 7'd127);
    write_reg(REG_ROW1, 7'd127);
    write_reg(REG_ROW2, 7'd127);
    write_reg(REG_ROW3, 7'd127);
    queue_req(OP_DATA, 8'h3C, 8'h00, 8'h00);
    queue_req(OP_COMMAND, 8'hC3, 8'h00, 8'h00);
    queue_req(OP_CLEAR, 8'h00, 8'h00, 8'h00);
    queue_req(OP_HOME, 8'h00, 8'h00, 8'h00);
    for (int r = 0; r < 4; r++) queue_req(OP_CURSOR, 8'h00, 8'hFF, 8'(r));
    queue_req(OP_INIT, 8'h00, 8'h00, 8'h00);
    settle();

    // Bottom extremes: line count zero counts as one line; spare indexes ignored
    write_reg(REG_FUNCTION, 7'd0);
    write_reg(REG_LINES, 7'd0);
    write_reg(REG_ROW0, 7'd0);
    write_reg(REG_ROW1, 7'd0);
    write_reg(REG_ROW2, 7'd0);
    write_reg(REG_ROW3, 7'd0);
    write_reg(REG_SPARE_6, 7'h7F);
    write_reg(REG_SPARE_7, 7'h55);
    queue_req(OP_CURSOR, 8'h00, 8'h80, 8'd3);
    queue_req(OP_INIT, 8'h00, 8'h00, 8'h00);
    queue_req(OP_DATA, 8'h00, 8'h00, 8'h00);

    // Random phases, each under a fresh register setting; one runs with no
    // idling at all, another starts with the long sink stall
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      steady = 1'b0;
      random_config();
      steady = (ph == 2);
      if (ph == 5) hold_armed = 1'b1;
      repeat (PHASE_REQUESTS) queue_random_req();
    end

    while (req_pending.size() != 0 || s_tvalid || snaps_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d power-up runs, %0d spare opcodes), %0d snapshots",
             req_beats, init_count, spare_count, snap_beats);
    $display("under %0d register writes, with a long sink stall and a no-idle stretch",
             reg_writes);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
